@@ src/bts_pkg.sv @@
package bts_pkg;

	// Texture store geometry and filter precision.
	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLUMNS = 256;
	localparam int WEIGHT_BITS = 8;

	// Fixed field widths of the interface.
	localparam int FRAC_W    = 16;
	localparam int CH_W      = 8;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// Derived widths of addresses, sizes and arithmetic.
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLUMNS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int TEX_DEPTH = 2 ** ADDR_W;
	localparam int TEXEL_W   = 3 * CH_W;
	localparam int HGT_W     = $clog2(MAX_ROWS + 1);
	localparam int WID_W     = $clog2(MAX_COLUMNS + 1);
	localparam int POS_U_W   = FRAC_W + HGT_W;
	localparam int POS_V_W   = FRAC_W + WID_W;
	localparam int WF_W      = WEIGHT_BITS + 1;
	localparam int WT_W      = 2 * WEIGHT_BITS + 1;
	localparam int PROD_W    = CH_W + WT_W;
	localparam int SUM_W     = PROD_W + 2;

	localparam logic [WF_W-1:0]  WEIGHT_ONE = WF_W'(1) << WEIGHT_BITS;
	localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (2 * WEIGHT_BITS - 1);
	localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(256);

	// Operation codes of an input word.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} texel_t;

	// Requests from the coordinate stage: texel write, four reads, weights.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		texel_t            wdata;
		logic [ADDR_W-1:0] raddr_11;
		logic [ADDR_W-1:0] raddr_12;
		logic [ADDR_W-1:0] raddr_21;
		logic [ADDR_W-1:0] raddr_22;
		logic              smp_valid;
		logic [WT_W-1:0]   w11;
		logic [WT_W-1:0]   w12;
		logic [WT_W-1:0]   w21;
		logic [WT_W-1:0]   w22;
	} fetch_req_t;

	typedef struct packed {
		logic   valid;
		texel_t px;
	} result_t;

	// Usable row count: zero acts as one, large values saturate.
	function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] value);
		logic [HGT_W-1:0] size;
		if (value == '0) begin
			size = HGT_W'(1);
		end else if (int'(value) > MAX_ROWS) begin
			size = HGT_W'(MAX_ROWS);
		end else begin
			size = HGT_W'(value);
		end
		return size;
	endfunction

	// Usable column count: zero acts as one, large values saturate.
	function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] value);
		logic [WID_W-1:0] size;
		if (value == '0) begin
			size = WID_W'(1);
		end else if (int'(value) > MAX_COLUMNS) begin
			size = WID_W'(MAX_COLUMNS);
		end else begin
			size = WID_W'(value);
		end
		return size;
	endfunction

endpackage

@@ src/bilinear_texture_sampler_wrap_unit.sv @@
// Bilinear texture sampler with repeat wrap.
// The input channel (in_valid, in_stall) carries one word per accepted cycle.
// A word with operation low writes one RGB texel at row and column and gives
// no result. A word with operation high samples the texture at the Q0.16
// coordinates frac_u and frac_v and gives one blended RGB word on the output
// channel (out_valid, out_stall). Results come out in input order.
// Throughput is one word per clock unless stalled: every stage, including the
// multiplies and the two texture copies that each serve two reads a cycle,
// takes a new word each cycle. A sample passes the registers of stages 1, 2
// and 3 and the output register. Writes take effect in the same stage where
// later samples read, so a sample always sees earlier writes.
// The configuration port sets image_height and image_width; the user must write
// it only while no word is in flight, as the block does not enforce this. Reset
// sets both sizes to 256 and empties the pipeline; texture contents are undefined
// until written. When the receiver stalls, the finished result waits in the
// output register and one more result goes into a spare slot; in_stall rises
// only when that slot is full, and it comes from a register.
module bilinear_texture_sampler_wrap_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [7:0]                     row,
	input  logic [7:0]                     column,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	input  logic [15:0]                    frac_u,
	input  logic [15:0]                    frac_v,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	input  logic                           cfg_we,
	input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bts_pkg::CFG_W-1:0]      cfg_data
);
	import bts_pkg::*;

	logic [HGT_W-1:0] height_q;
	logic [WID_W-1:0] width_q;
	logic             en;
	fetch_req_t       req;
	result_t          res;
	texel_t           t11, t12, t21, t22;

	// Configuration registers hold the sizes already clamped for use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= clamp_height(RESET_SIZE);
			width_q  <= clamp_width(RESET_SIZE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_HEIGHT: height_q <= clamp_height(cfg_data);
				REG_IMAGE_WIDTH:  width_q  <= clamp_width(cfg_data);
				default: ;
			endcase
		end
	end

	assign in_stall = !en;

	// Stage 1: capture, position scaling, then indexes and weights.
	bts_coord u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.operation (operation),
		.row       (row),
		.column    (column),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.frac_u    (frac_u),
		.frac_v    (frac_v),
		.height    (height_q),
		.width     (width_q),
		.req       (req)
	);

	// Two copies of the texture: one serves the first row, one the second.
	bts_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (TEX_DEPTH)
	) u_ram_row1 (
		.clk     (clk),
		.we      (req.we && en),
		.waddr   (req.waddr),
		.wdata   (req.wdata),
		.re      (en),
		.raddr_a (req.raddr_11),
		.raddr_b (req.raddr_12),
		.rdata_a (t11),
		.rdata_b (t12)
	);

	bts_ram #(
		.WIDTH (TEXEL_W),
		.DEPTH (TEX_DEPTH)
	) u_ram_row2 (
		.clk     (clk),
		.we      (req.we && en),
		.waddr   (req.waddr),
		.wdata   (req.wdata),
		.re      (en),
		.raddr_a (req.raddr_21),
		.raddr_b (req.raddr_22),
		.rdata_a (t21),
		.rdata_b (t22)
	);

	// Stages 2 and 3: products, then sums and rounding.
	bts_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (req),
		.t11    (t11),
		.t12    (t12),
		.t21    (t21),
		.t22    (t22),
		.res    (res)
	);

	// Output register with a spare slot.
	bts_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.arrive    (res),
		.en        (en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

endmodule

@@ src/bts_ram.sv @@
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two registered read ports that hold their data while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ src/bts_coord.sv @@
module bts_coord (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic                        operation,
	input  logic [7:0]                  row,
	input  logic [7:0]                  column,
	input  logic [7:0]                  red_in,
	input  logic [7:0]                  green_in,
	input  logic [7:0]                  blue_in,
	input  logic [15:0]                 frac_u,
	input  logic [15:0]                 frac_v,
	input  logic [bts_pkg::HGT_W-1:0]   height,
	input  logic [bts_pkg::WID_W-1:0]   width,
	output bts_pkg::fetch_req_t         req
);
	import bts_pkg::*;

	logic               valid_s1;
	logic               op_s1;
	logic               wok_s1;
	logic [ADDR_W-1:0]  waddr_s1;
	texel_t             wdata_s1;
	logic [POS_U_W-1:0] pu_s1;
	logic [POS_V_W-1:0] pv_s1;

	logic [HGT_W-1:0]       r1, r2;
	logic [WID_W-1:0]       c1, c2;
	logic [WEIGHT_BITS-1:0] fu, fv;
	logic [WF_W-1:0]        wu0, wu1, wv0, wv1;

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload: write address and texel, scaled sample positions.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= operation;
			wok_s1   <= (int'(row) < MAX_ROWS) && (int'(column) < MAX_COLUMNS);
			waddr_s1 <= {ROW_W'(row), COL_W'(column)};
			wdata_s1 <= '{red: red_in, green: green_in, blue: blue_in};
			pu_s1    <= POS_U_W'(frac_u) * POS_U_W'(height);
			pv_s1    <= POS_V_W'(frac_v) * POS_V_W'(width);
		end
	end

	// Texel indexes with repeat wrap of the neighbor.
	always_comb begin
		r1 = pu_s1[POS_U_W-1:FRAC_W];
		if (r1 >= height) begin
			r1 = HGT_W'(height - HGT_W'(1));
		end
		r2 = HGT_W'(r1 + HGT_W'(1));
		if (r2 >= height) begin
			r2 = '0;
		end
		c1 = pv_s1[POS_V_W-1:FRAC_W];
		if (c1 >= width) begin
			c1 = WID_W'(width - WID_W'(1));
		end
		c2 = WID_W'(c1 + WID_W'(1));
		if (c2 >= width) begin
			c2 = '0;
		end
	end

	// Fractions and their complements as bilinear weights.
	assign fu  = pu_s1[FRAC_W-1 -: WEIGHT_BITS];
	assign fv  = pv_s1[FRAC_W-1 -: WEIGHT_BITS];
	assign wu1 = WF_W'(fu);
	assign wv1 = WF_W'(fv);
	assign wu0 = WF_W'(WEIGHT_ONE - wu1);
	assign wv0 = WF_W'(WEIGHT_ONE - wv1);

	assign req.we        = valid_s1 && (op_s1 == OP_WRITE) && wok_s1;
	assign req.waddr     = waddr_s1;
	assign req.wdata     = wdata_s1;
	assign req.raddr_11  = {ROW_W'(r1), COL_W'(c1)};
	assign req.raddr_12  = {ROW_W'(r1), COL_W'(c2)};
	assign req.raddr_21  = {ROW_W'(r2), COL_W'(c1)};
	assign req.raddr_22  = {ROW_W'(r2), COL_W'(c2)};
	assign req.smp_valid = valid_s1 && (op_s1 == OP_SAMPLE);
	assign req.w11       = WT_W'(WT_W'(wu0) * WT_W'(wv0));
	assign req.w12       = WT_W'(WT_W'(wu0) * WT_W'(wv1));
	assign req.w21       = WT_W'(WT_W'(wu1) * WT_W'(wv0));
	assign req.w22       = WT_W'(WT_W'(wu1) * WT_W'(wv1));

endmodule

@@ src/bts_blend.sv @@
module bts_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bts_pkg::fetch_req_t req,
	input  bts_pkg::texel_t     t11,
	input  bts_pkg::texel_t     t12,
	input  bts_pkg::texel_t     t21,
	input  bts_pkg::texel_t     t22,
	output bts_pkg::result_t    res
);
	import bts_pkg::*;

	logic              valid_s2;
	logic [WT_W-1:0]   wt_s2 [4];
	logic              valid_s3;
	logic [PROD_W-1:0] prod_s3 [4][3];

	logic [CH_W-1:0]   chan [4][3];
	logic [PROD_W-1:0] prod [4][3];
	logic [SUM_W-1:0]  sum [3];
	logic [CH_W-1:0]   px [3];

	// Valid bits of stages 2 and 3; stage 2 lines up with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= req.smp_valid;
			valid_s3 <= valid_s2;
		end
	end

	// Channels of the four neighbors, red first.
	assign chan[0] = '{t11.red, t11.green, t11.blue};
	assign chan[1] = '{t12.red, t12.green, t12.blue};
	assign chan[2] = '{t21.red, t21.green, t21.blue};
	assign chan[3] = '{t22.red, t22.green, t22.blue};

	// Weighted channel products.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int c = 0; c < 3; c++) begin
				prod[k][c] = PROD_W'(chan[k][c]) * PROD_W'(wt_s2[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wt_s2[0] <= req.w11;
			wt_s2[1] <= req.w12;
			wt_s2[2] <= req.w21;
			wt_s2[3] <= req.w22;
			prod_s3  <= prod;
		end
	end

	// Sum of the four products per channel, rounded half up.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = ROUND_BIAS;
			for (int k = 0; k < 4; k++) begin
				sum[c] = SUM_W'(sum[c] + SUM_W'(prod_s3[k][c]));
			end
			px[c] = sum[c][2*WEIGHT_BITS +: CH_W];
		end
	end

	assign res.valid    = valid_s3;
	assign res.px.red   = px[0];
	assign res.px.green = px[1];
	assign res.px.blue  = px[2];

endmodule

@@ src/bts_skid.sv @@
module bts_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  bts_pkg::result_t arrive,
	output logic             en,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out
);
	import bts_pkg::*;

	logic   out_valid_q;
	logic   skid_valid_q;
	texel_t out_px_q;
	texel_t skid_px_q;
	logic   out_free;

	// The pipeline moves whenever the spare slot is empty.
	assign en       = !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// Occupancy of the output register and the spare slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= arrive.valid;
			end
		end else if (arrive.valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result words for the output register and the spare slot.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_px_q <= skid_valid_q ? skid_px_q : arrive.px;
		end else if (arrive.valid && !skid_valid_q) begin
			skid_px_q <= arrive.px;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_px_q.red;
	assign green_out = out_px_q.green;
	assign blue_out  = out_px_q.blue;

endmodule
